// ===== src/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types of the radar frequency-control loop.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int BINS       = 60;
    localparam int FRAMES     = 16;
    localparam int BIN_W      = $clog2(BINS) > 0 ? $clog2(BINS) : 1;
    localparam int SLOT_W     = $clog2(FRAMES);
    localparam int HIST_DEPTH = FRAMES * BINS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int SUM_AW     = BIN_W;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + SLOT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_WIDTH   = 3'd0,
        REG_DEV_THRESHOLD = 3'd1,
        REG_CONTROL_LIMIT = 3'd2,
        REG_DIRECTION     = 3'd3,
        REG_AFC_ENABLE    = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] DIR_SEARCH = 2'd0;
    localparam logic [1:0] DIR_UP     = 2'd1;
    localparam logic [1:0] DIR_DOWN   = 2'd2;
    localparam logic [1:0] DIR_IDLE   = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [10:0] THR_RESET     = 11'd540;
    localparam logic [10:0] UPPER_RESET   = 11'd900;
    localparam logic [10:0] LOWER_RESET   = 11'd500;
    localparam logic [11:0] CONTROL_RESET = 12'd860;
    localparam logic [11:0] LIMIT_RESET   = 12'd1300;
    localparam logic [11:0] DEV_RESET     = 12'd7;

endpackage

// ===== src/afc_ram.sv =====
// ----------------------------------------------------------------------------
// afc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module afc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/radar_afc_loop_core.sv =====
// ----------------------------------------------------------------------------
// radar_afc_loop_core
// Radar frequency-control loop: per-bin history averaging, frame peaks,
// lock tracking and control word stepping.
// ----------------------------------------------------------------------------
// One word is taken per cycle and each word passes through the stage-1
// registers and then the output registers; a result that waits on the output
// holds the input. Per-bin running sums of the three channels sit in
// one RAM and the 16-frame sample history in another; each sample word reads
// both at acceptance and writes them back when it leaves stage 1, with the sum
// forwarded when two words in a row hit the same bin. Until the history has
// been filled once, unwritten entries are treated as zero by the frame
// counters, so no clearing pass is needed after reset.
module radar_afc_loop_core
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [15:0]           center_sample,
    input  logic [15:0]           right_sample,
    input  logic [15:0]           left_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [11:0]           control_word,
    output logic [10:0]           lock_threshold,
    output logic                  centred,
    output logic [11:0]           right_level,
    output logic [11:0]           left_level,
    output logic                  locked,
    output logic [15:0]           fail_count,
    output logic                  frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [7:0]  pulse_width_reg;
    logic [11:0] dev_thr_reg;
    logic [11:0] limit_reg;
    logic [1:0]  dir_reg;
    logic        enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= '0;
            dev_thr_reg     <= DEV_RESET;
            limit_reg       <= LIMIT_RESET;
            dir_reg         <= DIR_SEARCH;
            enable_reg      <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PULSE_WIDTH:   pulse_width_reg <= cfg_data[7:0];
                REG_DEV_THRESHOLD: dev_thr_reg     <= cfg_data;
                REG_CONTROL_LIMIT: limit_reg       <= cfg_data;
                REG_DIRECTION:     dir_reg         <= cfg_data[1:0];
                REG_AFC_ENABLE:    enable_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // frame position
    logic [BIN_W-1:0]  bin_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              wrapped_reg;

    // stage 1
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [SAMPLE_W-1:0] s1_smp_reg [3];
    logic [BIN_W-1:0]    s1_bin_reg;
    logic [HIST_AW-1:0]  s1_pos_reg;
    logic                s1_first_reg;
    logic                s1_last_reg;
    logic                s1_hist_ok_reg;
    logic                s1_sum_ok_reg;
    logic                s1_fwd_reg;
    logic [3*SUM_W-1:0]  s1_fwd_sum_reg;

    logic accept;
    logic s1_adv;
    logic is_sample;

    assign s1_adv    = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign accept    = in_valid && in_ready;
    assign is_sample = (command == CMD_SAMPLE);

    logic [HIST_AW-1:0] pos_now;
    assign pos_now = HIST_AW'(slot_reg) * HIST_AW'(BINS) + HIST_AW'(bin_reg);

    // memories
    logic [3*SAMPLE_W-1:0] hist_rd;
    logic [3*SUM_W-1:0]    sum_rd;
    logic [3*SUM_W-1:0]    sum_new;
    logic                  wr_en;

    assign wr_en = s1_adv && (s1_cmd_reg == CMD_SAMPLE);

    afc_ram #(.WIDTH(3*SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_pos_reg),
        .wr_data ({s1_smp_reg[2], s1_smp_reg[1], s1_smp_reg[0]}),
        .rd_en   (accept && is_sample),
        .rd_addr (pos_now),
        .rd_data (hist_rd)
    );

    afc_ram #(.WIDTH(3*SUM_W), .DEPTH(BINS)) u_sum_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_bin_reg),
        .wr_data (sum_new),
        .rd_en   (accept && is_sample),
        .rd_addr (bin_reg),
        .rd_data (sum_rd)
    );

    logic last_now;
    assign last_now = (32'(bin_reg) + 32'd1 >= 32'(BINS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg      <= '0;
            slot_reg     <= '0;
            wrapped_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (accept && is_sample)
            begin
                if (last_now)
                begin
                    bin_reg <= '0;
                    if (32'(slot_reg) + 32'd1 < 32'(FRAMES))
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    else
                    begin
                        slot_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end
                end
                else
                begin
                    bin_reg <= bin_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg     <= command;
            s1_smp_reg[0]  <= center_sample;
            s1_smp_reg[1]  <= right_sample;
            s1_smp_reg[2]  <= left_sample;
            s1_bin_reg     <= bin_reg;
            s1_pos_reg     <= pos_now;
            s1_first_reg   <= (bin_reg == '0);
            s1_last_reg    <= last_now;
            s1_hist_ok_reg <= wrapped_reg;
            s1_sum_ok_reg  <= wrapped_reg || (slot_reg != '0);
            s1_fwd_reg     <= wr_en && (s1_bin_reg == bin_reg);
            s1_fwd_sum_reg <= sum_new;
        end
    end

    // stage 2: sums, peaks and frame close
    logic [SAMPLE_W-1:0] avg [3];
    logic [15:0]         peak_reg [3];
    logic [15:0]         peak_next [3];

    always_comb
    begin
        logic [SUM_W-1:0] old_sum;
        logic [SUM_W-1:0] old_h;
        logic [SUM_W-1:0] s;
        for (int c = 0; c < 3; c++)
        begin
            old_sum = s1_fwd_reg ? s1_fwd_sum_reg[c*SUM_W +: SUM_W]
                    : (s1_sum_ok_reg ? sum_rd[c*SUM_W +: SUM_W] : '0);
            old_h   = s1_hist_ok_reg ? SUM_W'(hist_rd[c*SAMPLE_W +: SAMPLE_W]) : '0;
            s       = old_sum - old_h + SUM_W'(s1_smp_reg[c]);
            sum_new[c*SUM_W +: SUM_W] = s;
            avg[c] = SAMPLE_W'(s / FRAMES);
            peak_next[c] = (s1_first_reg || avg[c] >= peak_reg[c]) ? avg[c] : peak_reg[c];
        end
    end

    // loop state
    logic        centred_reg, centred_next;
    logic        lock_reg, lock_next;
    logic [2:0]  lock_cnt_reg, lock_cnt_next;
    logic [15:0] fail_reg, fail_next;
    logic [11:0] rlev_reg, rlev_next;
    logic [11:0] llev_reg, llev_next;
    logic [10:0] thr_reg, thr_next;
    logic [10:0] upper_reg, upper_next;
    logic [10:0] lower_reg, lower_next;
    logic [11:0] ctl_reg, ctl_next;
    logic [2:0]  nudge_r_reg, nudge_r_next;
    logic [2:0]  nudge_l_reg, nudge_l_next;
    logic [2:0]  err_r_reg, err_r_next;
    logic [2:0]  err_l_reg, err_l_next;
    logic        fend_next;

    always_comb
    begin
        logic [12:0] c13;
        logic [12:0] lim13;
        logic [11:0] r;
        logic [11:0] l;
        centred_next  = centred_reg;
        lock_next     = lock_reg;
        lock_cnt_next = lock_cnt_reg;
        fail_next     = fail_reg;
        rlev_next     = rlev_reg;
        llev_next     = llev_reg;
        thr_next      = thr_reg;
        upper_next    = upper_reg;
        lower_next    = lower_reg;
        ctl_next      = ctl_reg;
        nudge_r_next  = nudge_r_reg;
        nudge_l_next  = nudge_l_reg;
        err_r_next    = err_r_reg;
        err_l_next    = err_l_reg;
        fend_next     = 1'b0;
        c13   = {1'b0, ctl_reg};
        lim13 = {1'b0, limit_reg};
        r     = rlev_reg;
        l     = llev_reg;

        if (s1_cmd_reg == CMD_SAMPLE)
        begin
            if (s1_last_reg)
            begin
                fend_next = 1'b1;
                if (peak_next[0] >= {5'd0, thr_reg})
                begin
                    centred_next = 1'b1;
                    if (lock_cnt_reg < 3'd5)
                    begin
                        lock_cnt_next = lock_cnt_reg + 3'd1;
                    end
                    else
                    begin
                        lock_next = 1'b1;
                    end
                end
                else
                begin
                    centred_next = 1'b0;
                    if (lock_cnt_reg < 3'd5)
                    begin
                        if (fail_reg != 16'hFFFF)
                        begin
                            fail_next = fail_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        lock_next     = 1'b0;
                        lock_cnt_next = '0;
                    end
                end
                rlev_next = peak_next[1][15:4];
                llev_next = peak_next[2][15:4];
            end
        end
        else if (enable_reg)
        begin
            if (centred_reg)
            begin
                err_r_next = '0;
                err_l_next = '0;
                if (pulse_width_reg < 8'd35)
                begin
                    upper_next = 11'd700;
                    lower_next = 11'd400;
                end
                else if (pulse_width_reg <= 8'd38)
                begin
                    upper_next = 11'd900;
                    lower_next = 11'd470;
                end
                else if (pulse_width_reg < 8'd45)
                begin
                    upper_next = 11'd1200;
                    lower_next = 11'd540;
                end
                else
                begin
                    upper_next = 11'd1300;
                    lower_next = 11'd600;
                end
                if (r != l && thr_reg < upper_next)
                begin
                    thr_next = thr_reg + 11'd10;
                end
                if (r > l && r > dev_thr_reg)
                begin
                    nudge_l_next = '0;
                    nudge_r_next = nudge_r_reg + 3'd1;
                    if (nudge_r_next > 3'd5)
                    begin
                        if (c13 + 13'd1 < lim13)
                        begin
                            ctl_next = ctl_reg + 12'd1;
                        end
                        nudge_r_next = '0;
                    end
                end
                else if (l >= r && l >= dev_thr_reg)
                begin
                    nudge_r_next = '0;
                    nudge_l_next = nudge_l_reg + 3'd1;
                    if (nudge_l_next > 3'd5)
                    begin
                        if (ctl_reg != '0)
                        begin
                            ctl_next = ctl_reg - 12'd1;
                        end
                        nudge_l_next = '0;
                    end
                end
            end
            else
            begin
                thr_next = (thr_reg > lower_reg) ? thr_reg - 11'd10 : lower_reg;
                if (!lock_reg)
                begin
                    if (r >= dev_thr_reg && r >= l)
                    begin
                        case (dir_reg)
                            DIR_SEARCH:
                            begin
                                err_r_next = err_r_reg + 3'd1;
                                if (err_r_next < 3'd6)
                                begin
                                    if (ctl_reg < limit_reg) ctl_next = ctl_reg + 12'd1;
                                end
                                else
                                begin
                                    ctl_next   = (ctl_reg > 12'd15) ? ctl_reg - 12'd15 : limit_reg;
                                    err_r_next = '0;
                                end
                            end
                            DIR_UP:   ctl_next = (ctl_reg < limit_reg) ? ctl_reg + 12'd1 : '0;
                            DIR_DOWN: ctl_next = (ctl_reg >= 12'd1) ? ctl_reg - 12'd1 : limit_reg;
                            default: ;
                        endcase
                    end
                    else if (l >= dev_thr_reg && l >= r)
                    begin
                        case (dir_reg)
                            DIR_SEARCH:
                            begin
                                err_l_next = err_l_reg + 3'd1;
                                if (err_l_next < 3'd6)
                                begin
                                    ctl_next = (ctl_reg > 12'd1) ? ctl_reg - 12'd1 : limit_reg;
                                end
                                else
                                begin
                                    ctl_next   = (ctl_reg > 12'd15) ? ctl_reg - 12'd15 : limit_reg;
                                    err_l_next = '0;
                                end
                            end
                            DIR_UP:   ctl_next = (ctl_reg > 12'd1) ? ctl_reg - 12'd1 : limit_reg;
                            DIR_DOWN: ctl_next = (ctl_reg < limit_reg) ? ctl_reg + 12'd1 : '0;
                            default: ;
                        endcase
                    end
                    else if (r < dev_thr_reg && l < dev_thr_reg)
                    begin
                        err_r_next = '0;
                        err_l_next = '0;
                        case (dir_reg)
                            DIR_SEARCH, DIR_DOWN:
                                ctl_next = (c13 + 13'd5 <= lim13) ? ctl_reg + 12'd5 : '0;
                            DIR_UP:
                                ctl_next = (ctl_reg >= 12'd5) ? ctl_reg - 12'd5 : limit_reg;
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                peak_reg[c] <= '0;
            end
            centred_reg  <= 1'b0;
            lock_reg     <= 1'b0;
            lock_cnt_reg <= '0;
            fail_reg     <= '0;
            rlev_reg     <= '0;
            llev_reg     <= '0;
            thr_reg      <= THR_RESET;
            upper_reg    <= UPPER_RESET;
            lower_reg    <= LOWER_RESET;
            ctl_reg      <= CONTROL_RESET;
            nudge_r_reg  <= '0;
            nudge_l_reg  <= '0;
            err_r_reg    <= '0;
            err_l_reg    <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                if (s1_cmd_reg == CMD_SAMPLE)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        peak_reg[c] <= peak_next[c];
                    end
                end
                centred_reg  <= centred_next;
                lock_reg     <= lock_next;
                lock_cnt_reg <= lock_cnt_next;
                fail_reg     <= fail_next;
                rlev_reg     <= rlev_next;
                llev_reg     <= llev_next;
                thr_reg      <= thr_next;
                upper_reg    <= upper_next;
                lower_reg    <= lower_next;
                ctl_reg      <= ctl_next;
                nudge_r_reg  <= nudge_r_next;
                nudge_l_reg  <= nudge_l_next;
                err_r_reg    <= err_r_next;
                err_l_reg    <= err_l_next;
                out_valid    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            control_word   <= ctl_next;
            lock_threshold <= thr_next;
            centred        <= centred_next;
            right_level    <= rlev_next;
            left_level     <= llev_next;
            locked         <= lock_next;
            fail_count     <= fail_next;
            frame_end      <= fend_next;
        end
    end

endmodule

// ===== bench/afc_checker.sv =====
// ----------------------------------------------------------------------------
// afc_checker
// Watches the sample, result and register channels of the frequency-control
// loop, keeps its own copy of the loop state and compares every result word
// field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module afc_checker
    import afc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  command,
    input  logic [15:0]           center_sample,
    input  logic [15:0]           right_sample,
    input  logic [15:0]           left_sample,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [11:0]           control_word,
    input  logic [10:0]           lock_threshold,
    input  logic                  centred,
    input  logic [11:0]           right_level,
    input  logic [11:0]           left_level,
    input  logic                  locked,
    input  logic [15:0]           fail_count,
    input  logic                  frame_end,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_total,
    output int                    pending
);

    typedef struct packed {
        logic [11:0] control_word;
        logic [10:0] lock_threshold;
        logic        centred;
        logic [11:0] right_level;
        logic [11:0] left_level;
        logic        locked;
        logic [15:0] fail_count;
        logic        frame_end;
    } afc_result_t;

    afc_result_t expected_results[$];

    logic [15:0] hist_c [HIST_DEPTH];
    logic [15:0] hist_r [HIST_DEPTH];
    logic [15:0] hist_l [HIST_DEPTH];
    int unsigned slot, bin, peak [3], lvl_r, lvl_l;
    int unsigned cen, lck, lcnt, fails, thr, upper, lower, ctl;
    int unsigned nudge_up, nudge_dn, err_r, err_l;
    int unsigned pw, dev_thr, ctl_lim, dir, afc_en;

    function automatic int unsigned hist_avg(ref logic [15:0] h [HIST_DEPTH], input int b);
        int unsigned s;
        s = 0;
        for (int f = 0; f < FRAMES; f++)
            s += h[f * BINS + b];
        return s / FRAMES;
    endfunction

    function automatic void step_jump_back();
        if (ctl > 15) ctl -= 15;
        else ctl = ctl_lim;
    endfunction

    function automatic void step_centred();
        err_r = 0;
        err_l = 0;
        if (pw < 35)
        begin
            upper = 700;
            lower = 400;
        end
        else if (pw <= 38)
        begin
            upper = 900;
            lower = 470;
        end
        else if (pw < 45)
        begin
            upper = 1200;
            lower = 540;
        end
        else
        begin
            upper = 1300;
            lower = 600;
        end
        if (lvl_r != lvl_l && thr < upper) thr += 10;
        if (lvl_r > lvl_l && lvl_r > dev_thr)
        begin
            nudge_dn = 0;
            nudge_up++;
            if (nudge_up > 5)
            begin
                if (ctl + 1 < ctl_lim) ctl++;
                nudge_up = 0;
            end
        end
        else if (lvl_l >= lvl_r && lvl_l >= dev_thr)
        begin
            nudge_up = 0;
            nudge_dn++;
            if (nudge_dn > 5)
            begin
                if (ctl > 0) ctl--;
                nudge_dn = 0;
            end
        end
    endfunction

    function automatic void step_tick();
        if (afc_en != 1) return;
        if (cen != 0)
        begin
            step_centred();
            return;
        end
        if (thr > lower) thr -= 10;
        else thr = lower;
        if (lck != 0) return;
        if (lvl_r >= dev_thr && lvl_r >= lvl_l)
        begin
            if (dir == DIR_SEARCH)
            begin
                err_r++;
                if (err_r < 6)
                begin
                    if (ctl < ctl_lim) ctl++;
                end
                else
                begin
                    step_jump_back();
                    err_r = 0;
                end
            end
            else if (dir == DIR_UP) ctl = (ctl < ctl_lim) ? ctl + 1 : 0;
            else if (dir == DIR_DOWN) ctl = (ctl >= 1) ? ctl - 1 : ctl_lim;
        end
        else if (lvl_l >= dev_thr && lvl_l >= lvl_r)
        begin
            if (dir == DIR_SEARCH)
            begin
                err_l++;
                if (err_l < 6) ctl = (ctl > 1) ? ctl - 1 : ctl_lim;
                else
                begin
                    step_jump_back();
                    err_l = 0;
                end
            end
            else if (dir == DIR_UP) ctl = (ctl > 1) ? ctl - 1 : ctl_lim;
            else if (dir == DIR_DOWN) ctl = (ctl < ctl_lim) ? ctl + 1 : 0;
        end
        else if (lvl_r < dev_thr && lvl_l < dev_thr)
        begin
            err_r = 0;
            err_l = 0;
            if (dir == DIR_SEARCH || dir == DIR_DOWN)
                ctl = (ctl + 5 <= ctl_lim) ? ctl + 5 : 0;
            else if (dir == DIR_UP)
                ctl = (ctl >= 5) ? ctl - 5 : ctl_lim;
        end
    endfunction

    function automatic afc_result_t predict_afc(logic cmd, logic [15:0] c, logic [15:0] r,
                                                logic [15:0] l);
        afc_result_t res;
        int unsigned b, pos, a [3];
        logic fe;
        fe = 0;
        if (cmd == CMD_SAMPLE)
        begin
            b = (bin < BINS) ? bin : 0;
            pos = slot * BINS + b;
            hist_c[pos] = c;
            hist_r[pos] = r;
            hist_l[pos] = l;
            a[0] = hist_avg(hist_c, b);
            a[1] = hist_avg(hist_r, b);
            a[2] = hist_avg(hist_l, b);
            for (int k = 0; k < 3; k++)
                if (b == 0 || a[k] >= peak[k]) peak[k] = a[k];
            if (b + 1 >= BINS)
            begin
                if (peak[0] >= thr)
                begin
                    cen = 1;
                    if (lcnt < 5) lcnt++;
                    else lck = 1;
                end
                else
                begin
                    cen = 0;
                    if (lcnt < 5)
                    begin
                        if (fails < 65535) fails++;
                    end
                    else
                    begin
                        lck = 0;
                        lcnt = 0;
                    end
                end
                lvl_r = (peak[1] >> 4) & 12'hfff;
                lvl_l = (peak[2] >> 4) & 12'hfff;
                bin = 0;
                slot = (slot + 1 < FRAMES) ? slot + 1 : 0;
                fe = 1;
            end
            else bin = b + 1;
        end
        else step_tick();
        res.control_word = ctl[11:0];
        res.lock_threshold = thr[10:0];
        res.centred = cen[0];
        res.right_level = lvl_r[11:0];
        res.left_level = lvl_l[11:0];
        res.locked = lck[0];
        res.fail_count = fails[15:0];
        res.frame_end = fe;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        afc_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_c[i] = 0;
                hist_r[i] = 0;
                hist_l[i] = 0;
            end
            slot = 0; bin = 0; peak[0] = 0; peak[1] = 0; peak[2] = 0;
            lvl_r = 0; lvl_l = 0; cen = 0; lck = 0; lcnt = 0; fails = 0;
            thr = THR_RESET; upper = UPPER_RESET; lower = LOWER_RESET;
            ctl = CONTROL_RESET; nudge_up = 0; nudge_dn = 0; err_r = 0; err_l = 0;
            pw = 0; dev_thr = DEV_RESET; ctl_lim = LIMIT_RESET; dir = DIR_SEARCH;
            afc_en = 1;
            expected_results.delete();
            fail_total = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation");
                    fail_total++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (control_word !== exp_res.control_word)
                    begin
                        $error("control_word exp %0d got %0d", exp_res.control_word,
                               control_word);
                        fail_total++;
                    end
                    if (lock_threshold !== exp_res.lock_threshold)
                    begin
                        $error("lock_threshold exp %0d got %0d", exp_res.lock_threshold,
                               lock_threshold);
                        fail_total++;
                    end
                    if (centred !== exp_res.centred)
                    begin
                        $error("centred exp %0d got %0d", exp_res.centred, centred);
                        fail_total++;
                    end
                    if (right_level !== exp_res.right_level)
                    begin
                        $error("right_level exp %0d got %0d", exp_res.right_level,
                               right_level);
                        fail_total++;
                    end
                    if (left_level !== exp_res.left_level)
                    begin
                        $error("left_level exp %0d got %0d", exp_res.left_level, left_level);
                        fail_total++;
                    end
                    if (locked !== exp_res.locked)
                    begin
                        $error("locked exp %0d got %0d", exp_res.locked, locked);
                        fail_total++;
                    end
                    if (fail_count !== exp_res.fail_count)
                    begin
                        $error("fail_count exp %0d got %0d", exp_res.fail_count, fail_count);
                        fail_total++;
                    end
                    if (frame_end !== exp_res.frame_end)
                    begin
                        $error("frame_end exp %0d got %0d", exp_res.frame_end, frame_end);
                        fail_total++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PULSE_WIDTH:   pw = cfg_data[7:0];
                    REG_DEV_THRESHOLD: dev_thr = cfg_data;
                    REG_CONTROL_LIMIT: ctl_lim = cfg_data;
                    REG_DIRECTION:     dir = cfg_data[1:0];
                    REG_AFC_ENABLE:    afc_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_afc(command, center_sample,
                                                       right_sample, left_sample));
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the frequency-control loop with directed and random sample and tick
// words across several register settings, stalls both sides at random and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb
    import afc_pkg::*;
();

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [15:0]           center_sample;
    logic [15:0]           right_sample;
    logic [15:0]           left_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [11:0]           control_word;
    logic [10:0]           lock_threshold;
    logic                  centred;
    logic [11:0]           right_level;
    logic [11:0]           left_level;
    logic                  locked;
    logic [15:0]           fail_count;
    logic                  frame_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_total;
    int                    pending;
    int                    cycle_count;
    bit                    calm;
    bit                    hold_off;

    radar_afc_loop_core dut (.*);

    afc_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 600000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 19);
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic send_word(logic cmd, logic [15:0] c, logic [15:0] r, logic [15:0] l);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        center_sample <= c;
        right_sample <= r;
        left_sample <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // one frame of bins at a centre level plus noise; strong frames count toward lock, weak ones toward failures
    task automatic send_frame(int level, int side_r, int side_l);
        for (int b = 0; b < BINS; b++)
            send_word(CMD_SAMPLE, 16'(level + $urandom_range(0, 255)),
                      16'(side_r + $urandom_range(0, 255)),
                      16'(side_l + $urandom_range(0, 255)));
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_word(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        in_valid = 0;
        command = 0;
        center_sample = 0;
        right_sample = 0;
        left_sample = 0;
        cfg_valid = 0;
        cfg_index = REG_PULSE_WIDTH;
        cfg_data = 0;
        calm = 0;
        hold_off = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_ticks(6);
        send_word(CMD_SAMPLE, 16'hffff, 16'hffff, 16'hffff);
        send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_word(CMD_SAMPLE, 16'haaaa, 16'h5555, 16'haaaa);
        send_word(CMD_SAMPLE, 16'h5555, 16'haaaa, 16'h5555);
        send_ticks(4);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_PULSE_WIDTH, 12'd0);
                    write_reg(REG_DEV_THRESHOLD, 12'd0);
                    write_reg(REG_CONTROL_LIMIT, 12'd4095);
                    write_reg(REG_DIRECTION, 12'(DIR_SEARCH));
                    write_reg(REG_AFC_ENABLE, 12'd1);
                end
                1:
                begin
                    write_reg(REG_PULSE_WIDTH, 12'd36);
                    write_reg(REG_DEV_THRESHOLD, 12'd4095);
                    write_reg(REG_CONTROL_LIMIT, 12'd0);
                    write_reg(REG_DIRECTION, 12'(DIR_UP));
                end
                2:
                begin
                    write_reg(REG_PULSE_WIDTH, 12'd40);
                    write_reg(REG_DEV_THRESHOLD, 12'd30);
                    write_reg(REG_CONTROL_LIMIT, 12'd20);
                    write_reg(REG_DIRECTION, 12'(DIR_DOWN));
                end
                3:
                begin
                    write_reg(REG_PULSE_WIDTH, 12'd255);
                    write_reg(REG_DIRECTION, 12'(DIR_IDLE));
                    write_reg(REG_AFC_ENABLE, 12'd0);
                end
                4:
                begin
                    write_reg(REG_AFC_ENABLE, 12'd1);
                    write_reg(REG_DIRECTION, 12'(DIR_SEARCH));
                    write_reg(REG_CONTROL_LIMIT, 12'd1300);
                    write_reg(REG_DEV_THRESHOLD, 12'd7);
                    write_reg(REG_PULSE_WIDTH, 12'd38);
                end
                default:
                begin
                    write_reg(REG_PULSE_WIDTH, 12'd45);
                    write_reg(REG_CONTROL_LIMIT, 12'd4);
                    calm = 1;
                end
            endcase
            if (phase == 2) hold_off = 1;
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 3))
                    0: send_frame(16'(40000), $urandom_range(0, 60000),
                                  $urandom_range(0, 60000));
                    1: send_frame(0, $urandom_range(0, 300), $urandom_range(0, 300));
                    2: send_frame($urandom_range(0, 20000), 30000, 100);
                    default: send_frame($urandom_range(8000, 12000), 100, 30000);
                endcase
                send_ticks($urandom_range(1, 12));
                if ($urandom_range(0, 3) == 0)
                    send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              16'($urandom));
            end
        end

        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/afc_pkg.sv
src/afc_ram.sv
src/radar_afc_loop_core.sv
bench/afc_checker.sv
bench/tb.sv
